>>> rtl/rps_pkg.sv
// shared widths, codes and types of the reflow profile sequencer
package rps_pkg;

    localparam int DEF_MAX_STAGES  = 4;
    localparam int NUM_DUR_REGS    = 4;
    localparam int STAGE_COUNT_W   = 3;
    localparam int NUM_W           = STAGE_COUNT_W + 1;
    localparam int DUR_W           = 16;
    localparam int ELAPSED_W       = 18;
    localparam int DELTA_W         = 8;
    localparam int CMD_W           = 2;
    localparam int MODE_W          = 3;
    localparam int STAGE_W         = 2;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 5;
    localparam int REG_IDX_W       = 3;

    localparam logic [STAGE_COUNT_W-1:0] STAGE_COUNT_RST = 3'd4;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ABORT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PREHEAT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SOAK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REFLOW  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COOL    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FAULT   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DONE    = 3'd6;

    localparam logic [REG_IDX_W-1:0] REG_STAGE_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DUR_0       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DUR_1       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DUR_2       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DUR_3       = 3'd4;

    typedef struct packed {
        logic [STAGE_COUNT_W-1:0]               stage_count;
        logic [NUM_DUR_REGS-1:0][DUR_W-1:0]     dur;
    } rps_cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [ELAPSED_W-1:0] elapsed;
        logic [STAGE_W-1:0]   stage;
        logic                 abort_flag;
    } rps_state_t;

endpackage

>>> rtl/rps_regs.sv
// apb configuration registers: stage count and stage durations
module rps_regs import rps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output rps_cfg_t              cfg
);

    logic [STAGE_COUNT_W-1:0]           stage_count_reg;
    logic [NUM_DUR_REGS-1:0][DUR_W-1:0] dur_reg;
    logic                               wr_en;
    logic [REG_IDX_W-1:0]               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_count_reg <= STAGE_COUNT_RST;
            dur_reg         <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STAGE_COUNT: stage_count_reg <= pwdata[STAGE_COUNT_W-1:0];
                REG_DUR_0:       dur_reg[0] <= pwdata[DUR_W-1:0];
                REG_DUR_1:       dur_reg[1] <= pwdata[DUR_W-1:0];
                REG_DUR_2:       dur_reg[2] <= pwdata[DUR_W-1:0];
                REG_DUR_3:       dur_reg[3] <= pwdata[DUR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STAGE_COUNT: prdata = APB_DATA_W'(stage_count_reg);
            REG_DUR_0:       prdata = APB_DATA_W'(dur_reg[0]);
            REG_DUR_1:       prdata = APB_DATA_W'(dur_reg[1]);
            REG_DUR_2:       prdata = APB_DATA_W'(dur_reg[2]);
            REG_DUR_3:       prdata = APB_DATA_W'(dur_reg[3]);
            default:         prdata = '0;
        endcase
    end

    assign cfg.stage_count = stage_count_reg;
    assign cfg.dur         = dur_reg;

endmodule

>>> rtl/rps_next.sv
// next run state and start refusal for one command beat
module rps_next import rps_pkg::*; #(
    parameter int MAX_STAGES = DEF_MAX_STAGES
) (
    input  rps_cfg_t             cfg,
    input  rps_state_t           cur,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [DELTA_W-1:0]   delta_secs,
    input  logic                 fault_in,
    output rps_state_t           nxt,
    output logic                 refused
);

    logic [NUM_W-1:0]                      n_use;
    logic [STAGE_COUNT_W-1:0]              last;
    logic [NUM_DUR_REGS-1:0][ELAPSED_W-1:0] pre;
    logic [MAX_STAGES-1:0][ELAPSED_W-1:0]  ends;
    logic [ELAPSED_W-1:0]                  total;
    logic [ELAPSED_W-1:0]                  last_dur;
    logic [ELAPSED_W:0]                    sum;
    logic [ELAPSED_W-1:0]                  el_new;
    logic [STAGE_COUNT_W-1:0]              idx;
    logic [MODE_W-1:0]                     idx_mode;
    logic                                  running;

    always_comb begin
        if (cfg.stage_count == '0) begin
            n_use = NUM_W'(1);
        end else if (NUM_W'(cfg.stage_count) > NUM_W'(MAX_STAGES)) begin
            n_use = NUM_W'(MAX_STAGES);
        end else begin
            n_use = NUM_W'(cfg.stage_count);
        end
    end

    assign last = STAGE_COUNT_W'(n_use - NUM_W'(1));

    // cumulative stage ends; stages without a register add nothing
    always_comb begin
        pre[0] = ELAPSED_W'(cfg.dur[0]);
        for (int k = 1; k < NUM_DUR_REGS; k++) begin
            pre[k] = pre[k-1] + ELAPSED_W'(cfg.dur[k]);
        end
        for (int i = 0; i < MAX_STAGES; i++) begin
            ends[i] = (i < NUM_DUR_REGS) ? pre[i] : pre[NUM_DUR_REGS-1];
        end
    end

    always_comb begin
        total    = '0;
        last_dur = '0;
        for (int i = 0; i < MAX_STAGES; i++) begin
            if (STAGE_COUNT_W'(i) == last) begin
                total = ends[i];
            end
        end
        for (int k = 0; k < NUM_DUR_REGS; k++) begin
            if (NUM_W'(k) == NUM_W'(last)) begin
                last_dur = ELAPSED_W'(cfg.dur[k]);
            end
        end
    end

    assign sum    = {1'b0, cur.elapsed} + (ELAPSED_W+1)'(delta_secs);
    assign el_new = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];

    // first stage whose end is at or after the elapsed time
    always_comb begin
        idx = last;
        for (int i = MAX_STAGES - 1; i >= 0; i--) begin
            if ((NUM_W'(i) < n_use) && (el_new <= ends[i])) begin
                idx = STAGE_COUNT_W'(i);
            end
        end
    end

    always_comb begin
        if (NUM_W'(idx) + NUM_W'(1) >= n_use) begin
            idx_mode = MODE_COOL;
        end else if (idx == STAGE_COUNT_W'(0)) begin
            idx_mode = MODE_PREHEAT;
        end else if (idx == STAGE_COUNT_W'(1)) begin
            idx_mode = MODE_SOAK;
        end else begin
            idx_mode = MODE_REFLOW;
        end
    end

    assign running = (cur.mode >= MODE_PREHEAT) && (cur.mode <= MODE_COOL);

    always_comb begin
        nxt     = cur;
        refused = 1'b0;
        unique case (cmd)
            CMD_TICK: begin
                if (running) begin
                    if (fault_in) begin
                        nxt.mode = MODE_FAULT;
                    end else if (cur.abort_flag) begin
                        nxt.elapsed = el_new;
                        nxt.stage   = last[STAGE_W-1:0];
                        nxt.mode    = (el_new >= total) ? MODE_DONE : MODE_COOL;
                    end else if (el_new >= total) begin
                        nxt.elapsed = el_new;
                        nxt.stage   = last[STAGE_W-1:0];
                        nxt.mode    = MODE_DONE;
                    end else begin
                        nxt.elapsed = el_new;
                        nxt.stage   = idx[STAGE_W-1:0];
                        nxt.mode    = idx_mode;
                    end
                end
            end
            CMD_START: begin
                if (cur.mode != MODE_IDLE || cfg.stage_count == '0) begin
                    refused = 1'b1;
                end else begin
                    nxt.elapsed    = '0;
                    nxt.stage      = '0;
                    nxt.mode       = MODE_PREHEAT;
                    nxt.abort_flag = 1'b0;
                end
            end
            CMD_ABORT: begin
                if (running) begin
                    nxt.abort_flag = 1'b1;
                    nxt.mode       = MODE_COOL;
                    nxt.stage      = last[STAGE_W-1:0];
                    nxt.elapsed    = total - last_dur;
                end
            end
            CMD_ACK: begin
                if (cur.mode == MODE_FAULT || cur.mode == MODE_DONE) begin
                    nxt = '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/reflow_profile_sequencer_top.sv
// top level: input beat register, run state, result register, apb registers
//
//  channel   ports                                   direction
//  command   s_valid s_ready s_cmd s_delta_secs      in
//            s_fault_in
//  result    m_valid m_ready m_run_code m_stage_now  out
//            m_elapsed_now m_start_refused
//  config    psel penable pwrite paddr pwdata        in / out
//            prdata pready
//
// a taken beat waits in the input register, then loads the result register;
// one beat per cycle while m_ready is high; the run state updates in the same
// cycle the result loads, so each beat sees the state left by the one before
// reset clears run state to idle, stage count to four and durations to zero
// a stalled result holds the input register, which then holds s_ready low
module reflow_profile_sequencer_top import rps_pkg::*; #(
    parameter int MAX_STAGES = DEF_MAX_STAGES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [DELTA_W-1:0]    s_delta_secs,
    input  logic                  s_fault_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MODE_W-1:0]     m_run_code,
    output logic [STAGE_W-1:0]    m_stage_now,
    output logic [ELAPSED_W-1:0]  m_elapsed_now,
    output logic                  m_start_refused,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    rps_cfg_t             cfg;
    rps_state_t           state_reg;
    rps_state_t           state_next;
    logic                 refused_next;
    logic                 in_vld_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [DELTA_W-1:0]   delta_reg;
    logic                 fault_reg;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    rps_state_t           out_reg;
    logic                 refused_reg;
    logic                 advance;

    rps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rps_next #(
        .MAX_STAGES (MAX_STAGES)
    ) u_next (
        .cfg        (cfg),
        .cur        (state_reg),
        .cmd        (cmd_reg),
        .delta_secs (delta_reg),
        .fault_in   (fault_reg),
        .nxt        (state_next),
        .refused    (refused_next)
    );

    assign advance      = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready      = !in_vld_reg || advance;
    assign out_vld_next = advance || (out_vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            out_vld_reg <= out_vld_next;
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            delta_reg <= s_delta_secs;
            fault_reg <= s_fault_in;
        end
        if (advance) begin
            out_reg     <= state_next;
            refused_reg <= refused_next;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_run_code      = out_reg.mode;
    assign m_stage_now     = out_reg.stage;
    assign m_elapsed_now   = out_reg.elapsed;
    assign m_start_refused = refused_reg;

endmodule
